FILE: src/csp_pkg.sv
`timescale 1ns / 1ps
package csp_pkg;

   // Item kinds.
   localparam logic [1:0] KIND_ENTER = 2'd0;
   localparam logic [1:0] KIND_LEAVE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   localparam int DepthWidth = 11;

   // Controller states.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic fetch;
      logic exec;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
   } stat_type;

endpackage

FILE: src/call_stack_profiler.sv
`timescale 1ns / 1ps
// Call stack profiler for nested code regions.
// Input channel: drive req_kind, req_region_id and req_timestamp with start
// high; the beat is taken at a clock edge where busy is low.
// Kind 0 enters a region, 1 leaves it, 2 reads the region statistics.
// Result channel: one beat per item, shown for a single cycle with rsp_valid
// high. The receiver cannot stall; it must take the beat in that cycle.
// The item is captured, the stack and stats memories are read into registers,
// the status and statistics are registered, then rsp_valid rises; busy falls
// in the same cycle, so a new item is taken only after the last is through.
// Each item goes through the registered reads of the stack and stats
// memories followed by their read-modify-write.
// After reset the stats memory is swept to its cleared values, one region
// per cycle, with busy high; the stack is emptied at once.
module call_stack_profiler
   import csp_pkg::*;
#(
   parameter int STACK_DEPTH  = 1024,
   parameter int REGION_COUNT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_region_id,
   input  logic [63:0]           req_timestamp,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [DepthWidth-1:0] rsp_stack_depth,
   output logic [63:0]           rsp_hit_count,
   output logic [63:0]           rsp_total_sum,
   output logic [63:0]           rsp_total_min,
   output logic [63:0]           rsp_nested_sum,
   output logic [63:0]           rsp_nested_min,
   output logic [63:0]           rsp_elapsed
);

   cmd_type  cmd;
   stat_type stat;

   // Controller sequences each item through the datapath.
   csp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Datapath holds the stack, the statistics and the result registers.
   csp_datapath #(
      .STACK_DEPTH  (STACK_DEPTH),
      .REGION_COUNT (REGION_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_region_id   (req_region_id),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_stack_depth (rsp_stack_depth),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_total_sum   (rsp_total_sum),
      .rsp_total_min   (rsp_total_min),
      .rsp_nested_sum  (rsp_nested_sum),
      .rsp_nested_min  (rsp_nested_min),
      .rsp_elapsed     (rsp_elapsed)
   );

endmodule

FILE: src/csp_ctrl.sv
`timescale 1ns / 1ps
module csp_ctrl
   import csp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;

   // Next state: clear sweep after reset, then fetch, execute, respond.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands decode directly from the state; load also needs start.
   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.fetch      = (state_ff == ST_FETCH);
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.respond    = (state_ff == ST_DONE);
      busy           = (state_ff != ST_IDLE);
   end

endmodule

FILE: src/csp_datapath.sv
`timescale 1ns / 1ps
module csp_datapath
   import csp_pkg::*;
#(
   parameter int STACK_DEPTH  = 1024,
   parameter int REGION_COUNT = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_region_id,
   input  logic [63:0]           req_timestamp,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [DepthWidth-1:0] rsp_stack_depth,
   output logic [63:0]           rsp_hit_count,
   output logic [63:0]           rsp_total_sum,
   output logic [63:0]           rsp_total_min,
   output logic [63:0]           rsp_nested_sum,
   output logic [63:0]           rsp_nested_min,
   output logic [63:0]           rsp_elapsed
);

   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DCW = $clog2(STACK_DEPTH + 1);
   localparam int RAW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam logic [DCW-1:0] DepthMax = DCW'(STACK_DEPTH);
   localparam logic [RAW-1:0] RegionLast = RAW'(REGION_COUNT - 1);
   // Rounded-up reciprocal of the region count, scaled by 2^16.
   localparam logic [16:0] RegionRecip = 17'((65536 + REGION_COUNT - 1) / REGION_COUNT);

   // Stack frames: begin, region and child time in one row.
   logic [135:0] stack_mem [STACK_DEPTH];
   // Region statistics: hits, total sum, total min, nested sum, nested min.
   logic [319:0] stats_mem [REGION_COUNT];

   logic [1:0]     kind_ff;
   logic [7:0]     id_ff;
   logic [63:0]    ts_ff;
   logic [RAW-1:0] region_ff;
   logic [DCW-1:0] depth_ff, depth_in;
   logic [RAW-1:0] clr_ff;
   logic [135:0]   top_ff;
   logic [63:0]    parent_child_ff;
   logic [319:0]   stat_rd_ff;
   logic [1:0]     status_ff;
   logic [63:0]    elapsed_ff;
   logic [319:0]   stat_out_ff;
   logic           valid_ff;

   logic [RAW-1:0] region_idx;
   logic [23:0]    id_prod;
   logic [7:0]     id_quot, id_rem;
   logic [DCW-1:0] top_pos, parent_pos;
   logic [SAW-1:0] top_addr, parent_addr, push_addr;
   logic [63:0]    delta, nest, t_min, n_min;
   logic [319:0]   stat_new;

   // The quotient of an 8-bit id comes exactly from the scaled reciprocal.
   assign id_prod = 24'(req_region_id) * 24'(RegionRecip);
   assign id_quot = id_prod[23:16];
   assign id_rem  = req_region_id - 8'(id_quot * 8'(REGION_COUNT));

   // Region index is the id taken modulo the region count.
   always_comb begin
      if (REGION_COUNT >= 256) begin
         region_idx = RAW'(req_region_id);
      end else begin
         region_idx = RAW'(id_rem);
      end
   end

   assign top_pos     = depth_ff - DCW'(1);
   assign parent_pos  = depth_ff - DCW'(2);
   assign top_addr    = top_pos[SAW-1:0];
   assign parent_addr = parent_pos[SAW-1:0];
   assign push_addr   = depth_ff[SAW-1:0];

   // Capture the item and sweep the stats memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + RAW'(1);
      end
      if (cmd.load) begin
         kind_ff   <= req_kind;
         id_ff     <= req_region_id;
         ts_ff     <= req_timestamp;
         region_ff <= region_idx;
      end
   end
   assign stat.clear_done = (clr_ff == RegionLast);

   // Fetch the top frame, the parent's child time and the region entry.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         top_ff          <= stack_mem[top_addr];
         parent_child_ff <= stack_mem[parent_addr][63:0];
         stat_rd_ff      <= stats_mem[region_ff];
      end
   end

   // Execute: decide the status and build the new statistics.
   assign delta = ts_ff - top_ff[135:72];
   assign nest  = top_ff[63:0];
   assign t_min = (delta < stat_rd_ff[191:128]) ? delta : stat_rd_ff[191:128];
   assign n_min = (nest < stat_rd_ff[63:0]) ? nest : stat_rd_ff[63:0];
   assign stat_new = {stat_rd_ff[319:256] + 64'd1, stat_rd_ff[255:192] + delta,
                      t_min, stat_rd_ff[127:64] + nest, n_min};

   logic [1:0] status_next;
   always_comb begin
      status_next = STATUS_OK;
      case (kind_ff)
         KIND_ENTER: begin
            if (depth_ff + DCW'(2) > DepthMax || depth_ff >= DepthMax - DCW'(1)) begin
               status_next = STATUS_OVERFLOW;
            end
         end
         KIND_LEAVE: begin
            if (depth_ff == '0) begin
               status_next = STATUS_EMPTY;
            end else if (top_ff[71:64] != id_ff) begin
               status_next = STATUS_MISMATCH;
            end
         end
         default: status_next = STATUS_OK;
      endcase
   end

   logic push_ok, pop_ok;
   assign push_ok = (kind_ff == KIND_ENTER) && (status_next == STATUS_OK);
   assign pop_ok  = (kind_ff == KIND_LEAVE) && (status_next == STATUS_OK);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.exec && push_ok) depth_in = depth_ff + DCW'(1);
      if (cmd.exec && pop_ok)  depth_in = depth_ff - DCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         valid_ff <= cmd.respond;
      end
      if (cmd.exec) begin
         status_ff   <= status_next;
         elapsed_ff  <= pop_ok ? delta : 64'd0;
         stat_out_ff <= pop_ok ? stat_new : stat_rd_ff;
      end
   end

   // Stack writes: push a fresh frame, or add time into the parent.
   always_ff @(posedge clock) begin
      if (cmd.exec && push_ok) begin
         stack_mem[push_addr] <= {ts_ff, id_ff, 64'd0};
      end else if (cmd.exec && pop_ok && depth_ff > DCW'(1)) begin
         stack_mem[parent_addr][63:0] <= parent_child_ff + delta;
      end
   end

   // Stats writes: the clear sweep, or the update of a completed leave.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         stats_mem[clr_ff] <= {64'd0, 64'd0, {64{1'b1}}, 64'd0, {64{1'b1}}};
      end else if (cmd.exec && pop_ok) begin
         stats_mem[region_ff] <= stat_new;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_stack_depth = DepthWidth'(depth_ff);
   assign rsp_hit_count   = stat_out_ff[319:256];
   assign rsp_total_sum   = stat_out_ff[255:192];
   assign rsp_total_min   = stat_out_ff[191:128];
   assign rsp_nested_sum  = stat_out_ff[127:64];
   assign rsp_nested_min  = stat_out_ff[63:0];
   assign rsp_elapsed     = elapsed_ff;

endmodule

FILE: src/csp_checker.sv
`timescale 1ns / 1ps
module csp_checker
   import csp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [1:0]            rsp_status,
   input logic [63:0]           rsp_elapsed
);

   // An accepted beat yields a result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result missing after accepted beat");

   // Results appear only while the block has been busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work");

   // Failed items report no elapsed time.
   a_elapsed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_elapsed == 64'd0))
      else $error("elapsed on failed item");

   // Results are single-cycle pulses.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held two cycles");

endmodule

bind call_stack_profiler csp_checker u_csp_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_elapsed     (rsp_elapsed)
);
